@@ rtl/hsit_pkg.sv @@
// Shared constants and types for the homography symmetric inlier test.
`timescale 1ns / 1ps

package hsit_pkg;

    localparam int COEF_WIDTH   = 48;
    localparam int COORD_WIDTH  = 24;

    localparam int SLOT_COUNT   = 18;
    localparam int SLOT_W       = 5;
    localparam int MATRIX_SLOTS = 9;
    localparam int PAIR_W       = 16;

    localparam int ERR_W = 24;
    localparam logic [ERR_W-1:0] ERR_MAX         = '1;
    localparam logic [ERR_W-1:0] THRESHOLD_RESET = 24'd768;

    // projected coordinates clamp at 2^CLAMP_EXP (Q16.8 units)
    localparam int CLAMP_EXP = 33;
    localparam int QUOT_BITS = CLAMP_EXP + 1;

    // sum of two squared distances below 2^(2*ERR_W+1)
    localparam int SUMSQ_W   = 2 * ERR_W + 1;
    localparam int ROOT_BITS = ERR_W + 1;

    localparam int DIV_LAT   = QUOT_BITS + 1;
    localparam int FRONT_LAT = 4;
    localparam int BACK_LAT  = 4;
    localparam int LANE_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT + ROOT_BITS + 1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             degenerate;
        logic [ERR_W-1:0] distance;
    } t_lane_result;

endpackage

@@ rtl/hsit_if.sv @@
// Input and result channel interfaces.
`timescale 1ns / 1ps

interface hsit_in_if #(
    parameter int COEF_W  = hsit_pkg::COEF_WIDTH,
    parameter int COORD_W = hsit_pkg::COORD_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [hsit_pkg::SLOT_W-1:0]    coef_index;
    logic signed [COEF_W-1:0]       coef_value;
    logic [hsit_pkg::PAIR_W-1:0]    pair_index;
    logic signed [COORD_W-1:0]      first_x;
    logic signed [COORD_W-1:0]      first_y;
    logic signed [COORD_W-1:0]      second_x;
    logic signed [COORD_W-1:0]      second_y;

    modport source (output valid, cmd, coef_index, coef_value, pair_index,
                    first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, cmd, coef_index, coef_value, pair_index,
                    first_x, first_y, second_x, second_y, output ready);
endinterface

interface hsit_out_if;
    logic                           valid;
    logic                           ready;
    logic [hsit_pkg::PAIR_W-1:0]    result_pair_index;
    logic                           is_inlier;
    logic [hsit_pkg::ERR_W-1:0]     error_sum;
    logic                           degenerate;

    modport source (output valid, result_pair_index, is_inlier, error_sum, degenerate,
                    input ready);
    modport sink   (input valid, result_pair_index, is_inlier, error_sum, degenerate,
                    output ready);
endinterface

@@ rtl/hsit_coef_table.sv @@
// Coefficient register file: forward matrix in slots 0-8, inverse in 9-17.
`timescale 1ns / 1ps

module hsit_coef_table #(
    parameter int COEF_W = hsit_pkg::COEF_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [hsit_pkg::SLOT_W-1:0]  i_index,
    input  logic signed [COEF_W-1:0]     i_data,
    output logic signed [COEF_W-1:0]     o_coef [hsit_pkg::SLOT_COUNT]
);

    logic signed [COEF_W-1:0] r_slot [hsit_pkg::SLOT_COUNT];

    // out-of-range slots are dropped
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < hsit_pkg::SLOT_COUNT; s++) begin
            if (i_we && (i_index == hsit_pkg::SLOT_W'(s))) begin
                r_slot[s] <= i_data;
            end
        end
    end

    assign o_coef = r_slot;

endmodule

@@ rtl/hsit_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
`timescale 1ns / 1ps

module hsit_div #(
    parameter int NUM_W = 82,
    parameter int DEN_W = 74
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [NUM_W-1:0]                  i_num,
    input  logic [DEN_W-1:0]                  i_den,
    output logic [hsit_pkg::QUOT_BITS-1:0]    o_quot,
    output logic                              o_ovf
);

    localparam int QB = hsit_pkg::QUOT_BITS;
    localparam int XW = DEN_W + QB + 1;

    logic [XW-1:0]    r_rem [QB];
    logic [DEN_W-1:0] r_den [QB];
    logic [QB-1:0]    r_q   [QB+1];
    logic             r_ovf [QB+1];

    // entry stage: quotient of 2^QB or more clamps anyway
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= XW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (XW'(i_num) >= (XW'(i_den) << QB));
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int BIT = QB - k;
        logic [XW-1:0] w_trial;
        logic          w_take;

        assign w_trial = XW'(r_den[k-1]) << BIT;
        assign w_take  = (r_rem[k-1] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= r_q[k-1] | (w_take ? (QB'(1) << BIT) : '0);
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_take ? (r_rem[k-1] - w_trial) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quot = r_q[QB];
    assign o_ovf  = r_ovf[QB];

endmodule

@@ rtl/hsit_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, floor result.
`timescale 1ns / 1ps

module hsit_sqrt (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [hsit_pkg::SUMSQ_W-1:0]      i_val,
    output logic [hsit_pkg::ROOT_BITS-1:0]    o_root
);

    localparam int RB = hsit_pkg::ROOT_BITS;
    localparam int VW = hsit_pkg::SUMSQ_W;
    localparam int TW = 2 * RB + 1;

    logic [VW-1:0] r_rem  [RB];
    logic [RB-1:0] r_root [RB];

    for (genvar s = 0; s < RB; s++) begin : g_stage
        localparam int BIT = RB - 1 - s;
        logic [VW-1:0] w_rem_in;
        logic [RB-1:0] w_root_in;
        logic [TW-1:0] w_trial;
        logic          w_take;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_val;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
        end

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
        assign w_trial = (TW'(w_root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        assign w_take  = (TW'(w_rem_in) >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= w_root_in | (w_take ? (RB'(1) << BIT) : '0);
                r_rem[s]  <= w_take ? VW'(TW'(w_rem_in) - w_trial) : w_rem_in;
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule

@@ rtl/hsit_project.sv @@
// One projection lane: matrix times point, divide by w, distance to target.
`timescale 1ns / 1ps

module hsit_project #(
    parameter int COEF_W  = hsit_pkg::COEF_WIDTH,
    parameter int COORD_W = hsit_pkg::COORD_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COEF_W-1:0]     i_coef [hsit_pkg::MATRIX_SLOTS],
    input  logic signed [COORD_W-1:0]    i_x,
    input  logic signed [COORD_W-1:0]    i_y,
    input  logic signed [COORD_W-1:0]    i_tx,
    input  logic signed [COORD_W-1:0]    i_ty,
    output hsit_pkg::t_lane_result       o_result
);

    localparam int LW   = COEF_W / 2;
    localparam int HW   = COEF_W - LW;
    localparam int PLW  = LW + 1 + COORD_W;
    localparam int PHW  = HW + COORD_W;
    localparam int PRW  = COEF_W + COORD_W;
    localparam int RW   = PRW + 2;
    localparam int NW   = RW + 8;
    localparam int QB   = hsit_pkg::QUOT_BITS;
    localparam int PMW  = hsit_pkg::CLAMP_EXP + 2;
    localparam int DXW  = ((COORD_W > PMW) ? COORD_W : PMW) + 1;
    localparam int EW   = hsit_pkg::ERR_W;
    localparam int T_DLY   = hsit_pkg::FRONT_LAT + hsit_pkg::DIV_LAT;
    localparam int NEG_DLY = hsit_pkg::DIV_LAT;
    localparam int DEG_DLY = hsit_pkg::LANE_LAT - hsit_pkg::FRONT_LAT - 1;
    // flag taken at the abs stage, read by the result stage after r7, r8 and the root
    localparam int SAT_DLY = hsit_pkg::ROOT_BITS + 3;
    localparam logic [QB-1:0] CLAMP_Q = QB'(1) << hsit_pkg::CLAMP_EXP;

    // stage 1: split partial products (row j, column m -> index 2j+m)
    logic signed [PLW-1:0]    r1_plo [6];
    logic signed [PHW-1:0]    r1_phi [6];
    logic signed [COEF_W-1:0] r1_c2  [3];
    // stage 2: full products
    logic signed [PRW-1:0]    r2_prod [6];
    logic signed [COEF_W-1:0] r2_c2   [3];
    // stage 3: homogeneous rows x, y, w
    logic signed [RW-1:0]     r3_row [3];
    // stage 4: magnitudes and signs
    logic [NW-1:0]            r4_nx, r4_ny;
    logic [RW-1:0]            r4_dw;
    logic                     r4_negx, r4_negy, r4_degen;

    logic [QB-1:0]            w_qx, w_qy;
    logic                     w_ovfx, w_ovfy;

    logic signed [COORD_W-1:0] r_tx_d [T_DLY];
    logic signed [COORD_W-1:0] r_ty_d [T_DLY];
    logic                      r_negx_d [NEG_DLY];
    logic                      r_negy_d [NEG_DLY];
    logic                      r_deg_d  [DEG_DLY];
    logic                      r_sat_d  [SAT_DLY];

    logic [QB-1:0]            w_cqx, w_cqy;
    logic signed [DXW-1:0]    w_px, w_py;
    logic signed [DXW-1:0]    r5_dx, r5_dy;
    logic [DXW-1:0]           w_ax, w_ay;
    logic [EW-1:0]            r6_ax, r6_ay;
    logic [2*EW-1:0]          r7_sqx, r7_sqy;
    logic [hsit_pkg::SUMSQ_W-1:0]   r8_sum;
    logic [hsit_pkg::ROOT_BITS-1:0] w_root;
    hsit_pkg::t_lane_result   r_result;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int m = 0; m < 2; m++) begin
                    r1_plo[2*j+m] <= $signed({1'b0, i_coef[3*j+m][LW-1:0]})
                                     * (m == 0 ? i_x : i_y);
                    r1_phi[2*j+m] <= $signed(i_coef[3*j+m][COEF_W-1:LW])
                                     * (m == 0 ? i_x : i_y);
                end
                r1_c2[j] <= i_coef[3*j+2];
            end

            for (int p = 0; p < 6; p++) begin
                r2_prod[p] <= $signed({r1_phi[p], {LW{1'b0}}})
                              + $signed({{(PRW-PLW){r1_plo[p][PLW-1]}}, r1_plo[p]});
            end
            r2_c2 <= r1_c2;

            // units of 2^-40: constant column is scaled by 256
            for (int j = 0; j < 3; j++) begin
                r3_row[j] <= $signed({{2{r2_prod[2*j][PRW-1]}}, r2_prod[2*j]})
                             + $signed({{2{r2_prod[2*j+1][PRW-1]}}, r2_prod[2*j+1]})
                             + $signed({{(RW-COEF_W-8){r2_c2[j][COEF_W-1]}},
                                        r2_c2[j], 8'b0});
            end

            r4_nx    <= {RW'(r3_row[0][RW-1] ? -r3_row[0] : r3_row[0]), 8'b0};
            r4_ny    <= {RW'(r3_row[1][RW-1] ? -r3_row[1] : r3_row[1]), 8'b0};
            r4_dw    <= RW'(r3_row[2][RW-1] ? -r3_row[2] : r3_row[2]);
            r4_negx  <= r3_row[0][RW-1] ^ r3_row[2][RW-1];
            r4_negy  <= r3_row[1][RW-1] ^ r3_row[2][RW-1];
            r4_degen <= (r3_row[2] == '0);
        end
    end

    hsit_div #(.NUM_W(NW), .DEN_W(RW)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r4_nx),
        .i_den  (r4_dw),
        .o_quot (w_qx),
        .o_ovf  (w_ovfx)
    );

    hsit_div #(.NUM_W(NW), .DEN_W(RW)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r4_ny),
        .i_den  (r4_dw),
        .o_quot (w_qy),
        .o_ovf  (w_ovfy)
    );

    // side lines that ride along with the divider and root stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx_d[0]   <= i_tx;
            r_ty_d[0]   <= i_ty;
            r_negx_d[0] <= r4_negx;
            r_negy_d[0] <= r4_negy;
            r_deg_d[0]  <= r4_degen;
            r_sat_d[0]  <= (w_ax > DXW'(hsit_pkg::ERR_MAX))
                           || (w_ay > DXW'(hsit_pkg::ERR_MAX));
            for (int k = 1; k < T_DLY; k++) begin
                r_tx_d[k] <= r_tx_d[k-1];
                r_ty_d[k] <= r_ty_d[k-1];
            end
            for (int k = 1; k < NEG_DLY; k++) begin
                r_negx_d[k] <= r_negx_d[k-1];
                r_negy_d[k] <= r_negy_d[k-1];
            end
            for (int k = 1; k < DEG_DLY; k++) begin
                r_deg_d[k] <= r_deg_d[k-1];
            end
            for (int k = 1; k < SAT_DLY; k++) begin
                r_sat_d[k] <= r_sat_d[k-1];
            end
        end
    end

    always_comb begin
        w_cqx = (w_ovfx || (w_qx > CLAMP_Q)) ? CLAMP_Q : w_qx;
        w_cqy = (w_ovfy || (w_qy > CLAMP_Q)) ? CLAMP_Q : w_qy;
        w_px  = r_negx_d[NEG_DLY-1] ? -$signed(DXW'(w_cqx)) : $signed(DXW'(w_cqx));
        w_py  = r_negy_d[NEG_DLY-1] ? -$signed(DXW'(w_cqy)) : $signed(DXW'(w_cqy));
        w_ax  = r5_dx[DXW-1] ? DXW'(-r5_dx) : DXW'(r5_dx);
        w_ay  = r5_dy[DXW-1] ? DXW'(-r5_dy) : DXW'(r5_dy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_dx  <= DXW'(r_tx_d[T_DLY-1]) - w_px;
            r5_dy  <= DXW'(r_ty_d[T_DLY-1]) - w_py;

            r6_ax  <= w_ax[EW-1:0];
            r6_ay  <= w_ay[EW-1:0];

            r7_sqx <= r6_ax * r6_ax;
            r7_sqy <= r6_ay * r6_ay;

            r8_sum <= hsit_pkg::SUMSQ_W'(r7_sqx) + hsit_pkg::SUMSQ_W'(r7_sqy);
        end
    end

    hsit_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_val  (r8_sum),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result.degenerate <= r_deg_d[DEG_DLY-1];
            r_result.distance <= (r_sat_d[SAT_DLY-1]
                                  || (w_root > hsit_pkg::ROOT_BITS'(hsit_pkg::ERR_MAX)))
                                 ? hsit_pkg::ERR_MAX : w_root[EW-1:0];
        end
    end

    assign o_result = r_result;

endmodule

@@ rtl/homography_symmetric_inlier_test.sv @@
// Top level: symmetric transfer error inlier test against a stored homography.
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Carries
// i_in      in   valid / ready    cmd, coef_index, coef_value, pair_index, two points
// o_out     out  valid / ready    result_pair_index, is_inlier, error_sum, degenerate
// i_cfg     in   i_cfg_we         inlier_threshold (i_cfg_data)
//
// One beat per cycle in, one per cycle out while o_out is not stalled; a pair's result
// passes through the input stage, the lane and the output register.
// Latency is set by the two pipelined dividers and the root extractor per lane.
// Load beats write the coefficient registers and produce no result.
// Synchronous active-low reset clears the valid bits and sets the threshold to 3.0 px.
// A stall on o_out freezes the whole pipeline at once; i_in.ready drops with it.

module homography_symmetric_inlier_test #(
    parameter int COEF_WIDTH  = hsit_pkg::COEF_WIDTH,
    parameter int COORD_WIDTH = hsit_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hsit_in_if.sink                       i_in,
    hsit_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [hsit_pkg::ERR_W-1:0]    i_cfg_data
);

    localparam int LAT = hsit_pkg::LANE_LAT;
    localparam int EW  = hsit_pkg::ERR_W;

    logic w_en;
    logic w_accept;

    logic [EW-1:0] r_thr;

    // input stage
    logic                            r_s0_valid;
    logic [hsit_pkg::PAIR_W-1:0]     r_s0_pid;
    logic signed [COORD_WIDTH-1:0]   r_s0_x1, r_s0_y1, r_s0_x2, r_s0_y2;

    logic signed [COEF_WIDTH-1:0]    w_coef [hsit_pkg::SLOT_COUNT];

    // valid and id ride next to the lanes
    logic                            r_vld [LAT];
    logic [hsit_pkg::PAIR_W-1:0]     r_pid [LAT];

    hsit_pkg::t_lane_result          w_fwd, w_inv;

    logic                            w_degen;
    logic [EW:0]                     w_raw_sum;
    logic [EW-1:0]                   w_sum;

    logic                            r_out_valid;
    logic [hsit_pkg::PAIR_W-1:0]     r_out_pid;
    logic                            r_out_inlier;
    logic [EW-1:0]                   r_out_sum;
    logic                            r_out_degen;

    // whole pipeline advances when the output register is free or being taken
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;
    assign w_accept   = i_in.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= hsit_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // coefficients change at the beat edge; a pair in the input stage has
    // already been multiplied by then, so beats keep their order
    hsit_coef_table #(.COEF_W(COEF_WIDTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_accept && (hsit_pkg::t_cmd'(i_in.cmd) == hsit_pkg::CMD_LOAD)),
        .i_index (i_in.coef_index),
        .i_data  (i_in.coef_value),
        .o_coef  (w_coef)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in.valid
                          && (hsit_pkg::t_cmd'(i_in.cmd) == hsit_pkg::CMD_TEST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_pid <= i_in.pair_index;
            r_s0_x1  <= i_in.first_x;
            r_s0_y1  <= i_in.first_y;
            r_s0_x2  <= i_in.second_x;
            r_s0_y2  <= i_in.second_y;
        end
    end

    // point one through H, compared with point two
    hsit_project #(.COEF_W(COEF_WIDTH), .COORD_W(COORD_WIDTH)) u_fwd (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_coef   (w_coef[0:8]),
        .i_x      (r_s0_x1),
        .i_y      (r_s0_y1),
        .i_tx     (r_s0_x2),
        .i_ty     (r_s0_y2),
        .o_result (w_fwd)
    );

    // point two through the inverse, compared with point one
    hsit_project #(.COEF_W(COEF_WIDTH), .COORD_W(COORD_WIDTH)) u_inv (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_coef   (w_coef[9:17]),
        .i_x      (r_s0_x2),
        .i_y      (r_s0_y2),
        .i_tx     (r_s0_x1),
        .i_ty     (r_s0_y1),
        .o_result (w_inv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= r_s0_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pid[0] <= r_s0_pid;
            for (int k = 1; k < LAT; k++) begin
                r_pid[k] <= r_pid[k-1];
            end
        end
    end

    // combine: a zero w on either side, or a sum that overflows, pins the sum at full scale
    always_comb begin
        w_degen   = w_fwd.degenerate || w_inv.degenerate;
        w_raw_sum = {1'b0, w_fwd.distance} + {1'b0, w_inv.distance};
        if (w_degen || w_raw_sum[EW]) begin
            w_sum = hsit_pkg::ERR_MAX;
        end else begin
            w_sum = w_raw_sum[EW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pid    <= r_pid[LAT-1];
            r_out_sum    <= w_sum;
            r_out_degen  <= w_degen;
            r_out_inlier <= !w_degen && (w_sum < r_thr);
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.result_pair_index = r_out_pid;
    assign o_out.is_inlier         = r_out_inlier;
    assign o_out.error_sum         = r_out_sum;
    assign o_out.degenerate        = r_out_degen;

endmodule
